### rtl/slri_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted list insert/remove block.
// Holds sizes, operation and status codes, and the cell link type. No dependencies.
package slri_pkg;

   localparam int CAPACITY = 16;
   localparam int FILL_W   = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // lt: the cell holds a valid entry below the operand
   // hit: this cell or one to its left holds an entry equal to the operand
   typedef struct packed {
      logic lt;
      logic hit;
   } link_type;

endpackage

### rtl/slri_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response transactions.
// Depends on slri_pkg.
interface slri_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 kind;
   logic signed [slri_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface slri_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           status;
   logic [slri_pkg::COUNT_W-1:0]         count;

   modport source (output valid, output status, output count, input ready);
   modport sink   (input valid, input status, input count, output ready);
endinterface

### rtl/sorted_list_insert_remove.sv
`timescale 1ns / 1ps
// Top level: sorted bounded list built as a row of compare-and-shift cells.
// Depends on slri_pkg, slri_if and slri_cell.
//
//   channel   dir   signals                        meaning
//   req_ch    in    valid ready kind value         insert (0) / remove (1) transaction
//   rsp_ch    out   valid ready status count       status and entry count after it
//
// One transaction per cycle while ready; cells update on accept except full inserts.
// The response is registered; it appears the cycle after accept.
// req_ch.ready drops only while a response waits and rsp_ch.ready is low.
// Synchronous reset empties the list at once; entries need no clearing.
module sorted_list_insert_remove (
   input  logic       clock,
   input  logic       reset,
   slri_req_if.sink   req_ch,
   slri_rsp_if.source rsp_ch
);
   import slri_pkg::*;

   logic [FILL_W-1:0]          fill_ff;
   logic [FILL_W-1:0]          fill_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   status_type                 rsp_status_ff;
   status_type                 rsp_status_in;
   logic [COUNT_W-1:0]         rsp_count_ff;

   logic                       accept;
   logic                       full;
   logic                       found;
   logic                       enable;
   logic                       valid   [CAPACITY];
   logic signed [VALUE_W-1:0]  entry   [CAPACITY];
   link_type                   link    [CAPACITY];
   link_type                   head_link;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (fill_ff == FILL_W'(CAPACITY));
   assign found        = link[CAPACITY-1].hit;
   assign enable       = accept && !((req_ch.kind == KIND_INSERT) && full);
   assign head_link    = '{lt: 1'b1, hit: 1'b0};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign valid[i] = (FILL_W'(i) < fill_ff);
      slri_cell u_cell (
         .clock       (clock),
         .enable      (enable),
         .kind        (req_ch.kind),
         .value       (req_ch.value),
         .valid       (valid[i]),
         .left_entry  ((i == 0) ? req_ch.value : entry[(i == 0) ? 0 : i-1]),
         .left_link   ((i == 0) ? head_link : link[(i == 0) ? 0 : i-1]),
         .right_entry (entry[(i == CAPACITY-1) ? i : i+1]),
         .entry       (entry[i]),
         .link        (link[i])
      );
   end

   always_comb begin
      fill_in       = fill_ff;
      rsp_status_in = ST_DONE;
      if (req_ch.kind == KIND_INSERT) begin
         if (full) begin
            rsp_status_in = ST_FULL;
         end else begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end else begin
         if (found) begin
            fill_in = fill_ff - FILL_W'(1);
         end else begin
            rsp_status_in = ST_NOT_FOUND;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= COUNT_W'(fill_in);
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.count  = rsp_count_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CAPACITY))
      else $error("fill above capacity");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff == COUNT_W'(fill_ff)))
      else $error("response count differs from fill");

   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_ch.kind == KIND_INSERT) && !full)
         |=> (fill_ff == $past(fill_ff) + FILL_W'(1)))
      else $error("insert did not grow the list");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_ch.kind == KIND_INSERT) && full)
         |=> (rsp_status_ff == ST_FULL) && $stable(fill_ff))
      else $error("insert into full list not refused");

endmodule

### rtl/slri_cell.sv
`timescale 1ns / 1ps
// One list cell: holds one entry, compares it with the operand and shifts
// toward either neighbor. Depends on slri_pkg.
module slri_cell (
   input  logic                                clock,
   input  logic                                enable,
   input  logic                                kind,
   input  logic signed [slri_pkg::VALUE_W-1:0] value,
   input  logic                                valid,
   input  logic signed [slri_pkg::VALUE_W-1:0] left_entry,
   input  slri_pkg::link_type                  left_link,
   input  logic signed [slri_pkg::VALUE_W-1:0] right_entry,
   output logic signed [slri_pkg::VALUE_W-1:0] entry,
   output slri_pkg::link_type                  link
);
   import slri_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;

   assign link.lt  = valid && (entry_ff < value);
   assign link.hit = left_link.hit || (valid && (entry_ff == value));

   always_comb begin
      entry_in = entry_ff;
      if (kind == KIND_INSERT) begin
         if (!link.lt) begin
            entry_in = left_link.lt ? value : left_entry;
         end
      end else begin
         if (link.hit) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule
